### hdl/pre_pkg.sv
// Shared constants for the particle resampling engine.
package pre_pkg;

  // Resampling modes
  localparam logic [1:0] MODE_NONE        = 2'd0;
  localparam logic [1:0] MODE_MULTINOMIAL = 2'd1;
  localparam logic [1:0] MODE_RESIDUAL    = 2'd2;

  // Register map (index = byte address / 4)
  localparam int unsigned CFG_ADDR_BITS = 3;
  localparam logic        REG_MODE      = 1'b0;
  localparam logic        REG_COUNT     = 1'b1;

  // Register reset values
  localparam logic [1:0] MODE_RESET  = MODE_MULTINOMIAL;
  localparam logic [8:0] COUNT_RESET = 9'd256;

  // Operation codes carried on s_tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

endpackage

### hdl/pre_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pre_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/particle_resampling_engine.sv
// Particle resampling engine: weight loading, multinomial and residual draws.
// Load transaction: accept, cumulative read, write; no result.
// Draw, mode 0: total fetch, dispatch, best check, then result. Mode 1: a 32x32 multiply per
//   32-bit chunk of the total, then a binary search with a cumulative RAM read in each step.
// Draw, mode 2: first draw of a round ranks all weights, comparing every pair on the
//   weight RAM port; each new position costs a copy-count divide of WB+IDXW+3 steps.
// rst (synchronous, active high) restores mode 1, count 256, clears counters; RAMs keep data.
module particle_resampling_engine #(
  parameter int unsigned MAX_PARTICLES = 256,
  parameter int unsigned WEIGHT_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] weight, [63:32] uniform
  input  logic        s_tuser,   // [0] operation
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] slot_index, [15:8] source_index
  output logic        m_tuser,   // [0] is_best
  output logic        m_tlast,   // last slot of the round
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [pre_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import pre_pkg::*;

  // ---------------------------------------------------------------------------
  // Widths
  // ---------------------------------------------------------------------------
  localparam int unsigned WB   = WEIGHT_BITS;
  localparam int unsigned IDXW = $clog2(MAX_PARTICLES);
  localparam int unsigned CW   = IDXW + 1;                 // counts 0..MAX
  localparam int unsigned TW   = WB + IDXW;                // cumulative sums
  localparam int unsigned NCH  = (TW + 31) / 32;           // 32-bit chunks of total
  localparam int unsigned PW   = 32 * (NCH + 1);           // uniform * total
  localparam int unsigned KW   = $clog2(NCH) + 1;
  localparam int unsigned NW   = WB + CW + 2;              // copy-count numerator
  localparam int unsigned DW   = $clog2(NW);
  localparam int unsigned OW   = (IDXW > 8) ? IDXW : 8;

  // ---------------------------------------------------------------------------
  // Sequencer state codes
  // ---------------------------------------------------------------------------
  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_LD_RD   = 5'd1;
  localparam logic [4:0] ST_LD_WR   = 5'd2;
  localparam logic [4:0] ST_DR_TOT  = 5'd3;
  localparam logic [4:0] ST_DR_DISP = 5'd4;
  localparam logic [4:0] ST_SO_RDI  = 5'd5;
  localparam logic [4:0] ST_SO_LATI = 5'd6;
  localparam logic [4:0] ST_SO_RDJ  = 5'd7;
  localparam logic [4:0] ST_SO_CMP  = 5'd8;
  localparam logic [4:0] ST_SO_WR   = 5'd9;
  localparam logic [4:0] ST_CC_RDS  = 5'd10;
  localparam logic [4:0] ST_CC_RDW  = 5'd11;
  localparam logic [4:0] ST_CC_MUL  = 5'd12;
  localparam logic [4:0] ST_CC_NUM  = 5'd13;
  localparam logic [4:0] ST_CC_DIV  = 5'd14;
  localparam logic [4:0] ST_CC_END  = 5'd15;
  localparam logic [4:0] ST_RES     = 5'd16;
  localparam logic [4:0] ST_RES_RD  = 5'd17;
  localparam logic [4:0] ST_MU_MUL  = 5'd18;
  localparam logic [4:0] ST_MU_ACC  = 5'd19;
  localparam logic [4:0] ST_MU_THR  = 5'd20;
  localparam logic [4:0] ST_MU_CHK  = 5'd21;
  localparam logic [4:0] ST_MU_CMP  = 5'd22;
  localparam logic [4:0] ST_BS_RD   = 5'd23;
  localparam logic [4:0] ST_BS_CMP  = 5'd24;
  localparam logic [4:0] ST_EMIT    = 5'd25;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0] resample_mode;
  logic [8:0] particle_count;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      resample_mode  <= MODE_RESET;
      particle_count <= COUNT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_MODE:  resample_mode  <= pwdata[1:0];
        REG_COUNT: particle_count <= pwdata[8:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MODE:  prdata = {30'd0, resample_mode};
      REG_COUNT: prdata = {23'd0, particle_count};
      default:   prdata = 32'd0;
    endcase
  end

  // Active particle count: 0 acts as 1, above the maximum clamps to it
  logic [CW-1:0] n;
  always_comb begin
    if (particle_count == 9'd0) begin
      n = CW'(1);
    end else if (32'(particle_count) > MAX_PARTICLES) begin
      n = CW'(MAX_PARTICLES);
    end else begin
      n = CW'(particle_count);
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [4:0]      state;
  logic [WB-1:0]   w_in;
  logic [31:0]     u_in;
  logic [CW-1:0]   load_counter;
  logic [CW-1:0]   slot_counter;
  logic [CW-1:0]   residual_position;
  logic [CW-1:0]   copies_left;
  logic [WB-1:0]   best_weight;
  logic [IDXW-1:0] ld_idx;
  logic [IDXW-1:0] slot;
  logic [IDXW-1:0] src;
  logic [TW-1:0]   total;
  // rank pass
  logic [IDXW-1:0] si;
  logic [IDXW-1:0] sj;
  logic [IDXW-1:0] rank_cnt;
  logic [WB-1:0]   wi;
  // copy-count divider
  logic [WB+CW-1:0] prod;
  logic [NW-1:0]    num;
  logic [NW-1:0]    quo;
  logic [TW+1:0]    rem;
  logic [DW-1:0]    dcnt;
  // multinomial search
  logic [KW-1:0]   k;
  logic [63:0]     pp;
  logic [PW-1:0]   acc;
  logic [TW:0]     thr;
  logic [CW-1:0]   lo;
  logic [CW-1:0]   hi;
  // result
  logic [IDXW-1:0] res_slot;
  logic [IDXW-1:0] res_src;
  logic            res_best;
  logic            res_last;

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic            w_we,  c_we,  o_we;
  logic [IDXW-1:0] w_raddr, c_raddr, o_raddr, o_waddr;
  logic [WB-1:0]   w_rdata;
  logic [TW-1:0]   c_rdata, c_wdata;
  logic [IDXW-1:0] o_rdata;

  pre_ram #(.WIDTH(WB), .DEPTH(MAX_PARTICLES)) u_weight_ram (
    .clk(clk), .we(w_we), .waddr(ld_idx), .wdata(w_in),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  pre_ram #(.WIDTH(TW), .DEPTH(MAX_PARTICLES)) u_cumulative_ram (
    .clk(clk), .we(c_we), .waddr(ld_idx), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  pre_ram #(.WIDTH(IDXW), .DEPTH(MAX_PARTICLES)) u_order_ram (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(si),
    .raddr(o_raddr), .rdata(o_rdata)
  );

  // ---------------------------------------------------------------------------
  // Shared datapath helpers
  // ---------------------------------------------------------------------------
  logic          s_fire;
  logic          out_free;
  logic [CW-1:0] mid;
  logic [31:0]   chunk;
  logic [TW+1:0] div_den;
  logic [TW+1:0] rem_sh;
  logic          pos_live;

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign mid      = CW'((lo + hi) >> 1);
  assign chunk    = 32'(((32 * NCH)'(total)) >> (32 * k));
  assign div_den  = (TW + 2)'({total, 1'b0});
  assign rem_sh   = {rem[TW:0], num[NW-1]};
  assign pos_live = (residual_position < n);

  assign c_wdata = (ld_idx == '0) ? TW'(w_in) : c_rdata + TW'(w_in);
  assign w_we    = (state == ST_LD_WR);
  assign c_we    = (state == ST_LD_WR);
  assign o_we    = (state == ST_SO_WR);
  assign o_waddr = rank_cnt;
  assign o_raddr = pos_live ? residual_position[IDXW-1:0] : '0;

  always_comb begin
    case (state)
      ST_SO_RDI: w_raddr = si;
      ST_SO_RDJ: w_raddr = sj;
      ST_CC_RDW: w_raddr = o_rdata;
      default:   w_raddr = src;
    endcase
  end

  always_comb begin
    case (state)
      ST_LD_RD:  c_raddr = ld_idx - 1'b1;
      ST_DR_TOT: c_raddr = IDXW'(n - 1'b1);
      default:   c_raddr = mid[IDXW-1:0];
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      load_counter      <= '0;
      slot_counter      <= '0;
      residual_position <= '0;
      copies_left       <= '0;
      best_weight       <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            w_in <= WB'(s_tdata[31:0]);
            u_in <= s_tdata[63:32];
            if (s_tuser == OP_LOAD) begin
              ld_idx <= (load_counter >= n) ? '0 : load_counter[IDXW-1:0];
              state  <= ST_LD_RD;
            end else begin
              slot  <= (slot_counter >= n) ? '0 : slot_counter[IDXW-1:0];
              state <= ST_DR_TOT;
            end
          end
        end

        // ---- load: cumulative of previous entry, then write both stores
        ST_LD_RD: state <= ST_LD_WR;
        ST_LD_WR: begin
          load_counter      <= ((CW'(ld_idx) + 1'b1) >= n) ? '0 : CW'(ld_idx) + 1'b1;
          slot_counter      <= '0;
          residual_position <= '0;
          copies_left       <= '0;
          state             <= ST_IDLE;
        end

        // ---- draw: fetch total, dispatch on mode
        ST_DR_TOT: state <= ST_DR_DISP;
        ST_DR_DISP: begin
          total <= c_rdata;
          if (slot == '0) begin
            best_weight <= '0;
          end
          if (resample_mode == MODE_RESIDUAL) begin
            if (slot == '0) begin
              si    <= '0;
              state <= ST_SO_RDI;
            end else begin
              state <= ST_RES;
            end
          end else if (resample_mode == MODE_MULTINOMIAL) begin
            k     <= '0;
            acc   <= '0;
            state <= ST_MU_MUL;
          end else begin
            src   <= slot;
            state <= ST_BS_RD;
          end
        end

        // ---- ranking: rank(i) = heavier entries + equal entries of lower index
        ST_SO_RDI: state <= ST_SO_LATI;
        ST_SO_LATI: begin
          wi       <= w_rdata;
          sj       <= '0;
          rank_cnt <= '0;
          state    <= ST_SO_RDJ;
        end
        ST_SO_RDJ: state <= ST_SO_CMP;
        ST_SO_CMP: begin
          if ((w_rdata > wi) || ((w_rdata == wi) && (sj < si))) begin
            rank_cnt <= rank_cnt + 1'b1;
          end
          if (CW'(sj) == n - 1'b1) begin
            state <= ST_SO_WR;
          end else begin
            sj    <= sj + 1'b1;
            state <= ST_SO_RDJ;
          end
        end
        ST_SO_WR: begin
          if (CW'(si) == n - 1'b1) begin
            residual_position <= '0;
            state             <= ST_CC_RDS;
          end else begin
            si    <= si + 1'b1;
            state <= ST_SO_RDI;
          end
        end

        // ---- copy count round(w*N/total) for the particle at residual_position
        ST_CC_RDS: state <= ST_CC_RDW;
        ST_CC_RDW: state <= ST_CC_MUL;
        ST_CC_MUL: begin
          prod  <= (WB + CW)'(w_rdata) * (WB + CW)'(n);
          state <= ST_CC_NUM;
        end
        ST_CC_NUM: begin
          if (total == '0) begin
            copies_left <= '0;
            state       <= ST_RES;
          end else begin
            num   <= NW'({prod, 1'b0}) + NW'(total);
            rem   <= '0;
            quo   <= '0;
            dcnt  <= '0;
            state <= ST_CC_DIV;
          end
        end
        ST_CC_DIV: begin
          // restoring divide, one quotient bit a cycle
          if (rem_sh >= div_den) begin
            rem <= rem_sh - div_den;
            quo <= {quo[NW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[NW-2:0], 1'b0};
          end
          num  <= {num[NW-2:0], 1'b0};
          dcnt <= dcnt + 1'b1;
          if (dcnt == DW'(NW - 1)) begin
            state <= ST_CC_END;
          end
        end
        ST_CC_END: begin
          copies_left <= (quo > NW'(n)) ? n : CW'(quo);
          state       <= ST_RES;
        end

        // ---- residual walk: skip exhausted positions, else take one copy
        ST_RES: begin
          if (pos_live && (copies_left == '0)) begin
            residual_position <= residual_position + 1'b1;
            if ((residual_position + 1'b1) < n) begin
              state <= ST_CC_RDS;
            end
          end else begin
            if (pos_live) begin
              copies_left <= copies_left - 1'b1;
            end
            state <= ST_RES_RD;
          end
        end
        ST_RES_RD: begin
          src   <= o_rdata;
          state <= ST_BS_RD;
        end

        // ---- multinomial: threshold = ceil(u*total / 2^32), then binary search
        ST_MU_MUL: begin
          pp    <= 64'(u_in) * 64'(chunk);
          state <= ST_MU_ACC;
        end
        ST_MU_ACC: begin
          acc <= acc + (PW'(pp) << (32 * k));
          if (k == KW'(NCH - 1)) begin
            state <= ST_MU_THR;
          end else begin
            k     <= k + 1'b1;
            state <= ST_MU_MUL;
          end
        end
        ST_MU_THR: begin
          thr   <= (TW + 1)'(acc[PW-1:32]) + (TW + 1)'(acc[31:0] != 32'd0);
          lo    <= '0;
          hi    <= n - 1'b1;
          state <= ST_MU_CHK;
        end
        ST_MU_CHK: begin
          if (hi > lo) begin
            state <= ST_MU_CMP;
          end else begin
            src   <= lo[IDXW-1:0];
            state <= ST_BS_RD;
          end
        end
        ST_MU_CMP: begin
          if ({1'b0, c_rdata} >= thr) begin
            hi <= mid;
          end else begin
            lo <= mid + 1'b1;
          end
          state <= ST_MU_CHK;
        end

        // ---- best tracking and result
        ST_BS_RD: state <= ST_BS_CMP;
        ST_BS_CMP: begin
          res_slot <= slot;
          res_src  <= src;
          res_last <= ((CW'(slot) + 1'b1) == n);
          res_best <= 1'b0;
          if ((slot == '0) || (w_rdata >= best_weight)) begin
            best_weight <= w_rdata;
            res_best    <= 1'b1;
          end
          slot_counter <= ((CW'(slot) + 1'b1) >= n) ? '0 : CW'(slot) + 1'b1;
          state        <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output valid: set when a result is handed over, cleared once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_EMIT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output payload register, loaded with the transaction
  logic [OW-1:0] slot_ext, src_ext;
  assign slot_ext = OW'(res_slot);
  assign src_ext  = OW'(res_src);

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && out_free) begin
      m_tdata <= {src_ext[7:0], slot_ext[7:0]};
      m_tuser <= res_best;
      m_tlast <= res_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Search window never inverts
  a_search_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MU_CHK) |-> (lo <= hi))
    else $error("binary search window inverted");

  // Divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CC_DIV) |-> (rem < div_den))
    else $error("divider remainder out of range");

  // A load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (s_fire && (s_tuser == OP_LOAD)) |=> ##1 !$rose(m_tvalid))
    else $error("result raised by a load transaction");

endmodule

### verif/particle_resampling_engine_tb.sv
// Self-checking testbench for the particle resampling engine.
module particle_resampling_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pre_pkg::*;

  localparam int unsigned NPART = 256;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_MODE = {1'b0, REG_MODE, 1'b0} << 1;
  localparam logic [2:0] ADDR_COUNT = {1'b0, REG_COUNT, 1'b0} << 1;
  localparam longint CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [7:0] slot;
    logic [7:0] source;
    logic       best;
    logic       last;
  } draw_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // [31:0] weight, [63:32] uniform
  logic        s_tuser = OP_LOAD; // [0] operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [7:0] slot_index, [15:8] source_index
  logic        m_tuser;        // [0] is_best
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  particle_resampling_engine u_dut (.*);

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the engine: registers, stores and round counters
  // ---------------------------------------------------------------------------
  logic [1:0]  mode_reg;
  logic [8:0]  count_reg;
  logic [31:0] weights [NPART];
  logic [63:0] cumsum [NPART];
  int unsigned rank [NPART];
  bit          loaded [NPART];
  int unsigned load_ptr, slot_ptr, res_pos, copies_left;
  logic [31:0] best_w;

  draw_result_t pending_draws[$];

  int tx_idle = 0, rx_idle = 0;
  int n_items = 0, n_draws = 0, n_results = 0, n_errors = 0;
  int draws_by_mode [4] = '{0, 0, 0, 0};
  longint cycles = 0;

  function automatic int unsigned particles_in_use();
    if (count_reg == 0) return 1;
    if (count_reg > NPART) return NPART;
    return count_reg;
  endfunction

  function automatic bit all_loaded(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      if (!loaded[i]) return 0;
    return 1;
  endfunction

  // round(w*n/total), saturated at n; zero total gives no copies
  function automatic int unsigned copies_of(int unsigned idx, int unsigned n);
    logic [63:0] total, c;
    total = cumsum[n-1];
    if (total == 0) return 0;
    c = (64'd2 * weights[idx] * n + total) / (64'd2 * total);
    return (c > n) ? n : 32'(c);
  endfunction

  // stable descending-weight order over particles 0..n-1
  function automatic void rank_particles(int unsigned n);
    int unsigned j;
    for (int unsigned i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && weights[rank[j-1]] < weights[i]) begin
        rank[j] = rank[j-1];
        j--;
      end
      rank[j] = i;
    end
  endfunction

  // smallest index with cum * 2^32 >= u * total
  function automatic int unsigned search_pick(logic [31:0] u, int unsigned n);
    logic [95:0] rhs;
    int unsigned lo, hi, mid;
    rhs = 96'(u) * 96'(cumsum[n-1]);
    lo = 0;
    hi = n - 1;
    mid = (lo + hi) / 2;
    while (hi > lo) begin
      if ({cumsum[mid], 32'd0} >= rhs) hi = mid;
      else lo = mid + 1;
      mid = (lo + hi) / 2;
    end
    return mid;
  endfunction

  function automatic int unsigned residual_next(int unsigned n);
    while (res_pos < n && copies_left == 0) begin
      res_pos++;
      if (res_pos < n) copies_left = copies_of(rank[res_pos], n);
    end
    if (res_pos >= n) return rank[0];
    copies_left--;
    return rank[res_pos];
  endfunction

  function automatic void engine_reset();
    mode_reg = MODE_RESET;
    count_reg = COUNT_RESET;
    load_ptr = 0;
    slot_ptr = 0;
    res_pos = 0;
    copies_left = 0;
    best_w = '0;
    foreach (loaded[i]) begin
      loaded[i] = 0;
      weights[i] = '0;
      cumsum[i] = '0;
      rank[i] = 0;
    end
  endfunction

  // Advance the shadow by one accepted transaction and, for a draw, queue the expected result.
  function automatic void predict_transaction(logic op, logic [31:0] wt, logic [31:0] u);
    int unsigned n, idx, slot, src;
    draw_result_t r;
    n = particles_in_use();
    if (op == OP_LOAD) begin
      idx = (load_ptr >= n) ? 0 : load_ptr;
      weights[idx] = wt;
      cumsum[idx] = (idx == 0) ? 64'(wt) : cumsum[idx-1] + wt;
      loaded[idx] = 1;
      load_ptr = (idx + 1 >= n) ? 0 : idx + 1;
      slot_ptr = 0;
      res_pos = 0;
      copies_left = 0;
      return;
    end
    if (slot_ptr >= n) slot_ptr = 0;
    slot = slot_ptr;
    if (slot == 0) begin
      best_w = '0;
      if (mode_reg == MODE_RESIDUAL) begin
        rank_particles(n);
        res_pos = 0;
        copies_left = copies_of(rank[0], n);
      end
    end
    case (mode_reg)
      MODE_MULTINOMIAL: src = search_pick(u, n);
      MODE_RESIDUAL:    src = residual_next(n);
      default:          src = slot;
    endcase
    r.best = 1'b0;
    if (slot == 0 || weights[src] >= best_w) begin
      best_w = weights[src];
      r.best = 1'b1;
    end
    r.slot = slot[7:0];
    r.source = src[7:0];
    r.last = (slot + 1 == n);
    slot_ptr = (slot + 1 >= n) ? 0 : slot + 1;
    pending_draws.insert(pending_draws.size(), r);
    draws_by_mode[mode_reg]++;
    n_draws++;
  endfunction

  // ---------------------------------------------------------------------------
  // Stream driver, result sink and checker
  // ---------------------------------------------------------------------------
  task automatic send_transaction(logic op, logic [31:0] wt, logic [31:0] u);
    @(negedge clk);
    if ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < tx_idle);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {u, wt};
    do @(posedge clk); while (!s_tready);
    predict_transaction(op, wt, u);
    n_items++;
  endtask

  task automatic load(logic [31:0] wt);
    send_transaction(OP_LOAD, wt, $urandom());
  endtask

  task automatic draw(logic [31:0] u);
    send_transaction(OP_DRAW, $urandom(), u);
  endtask

  // Drop valid, let every expected draw come back, then give a trailing load
  // time to finish before anything touches the registers.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_draws.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  always @(negedge clk)
    m_tready <= !rst && ($urandom_range(99) >= rx_idle);

  always @(posedge clk) begin
    draw_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (pending_draws.size() == 0) begin
        $error("unexpected draw result: slot %0d source %0d", m_tdata[7:0], m_tdata[15:8]);
        n_errors++;
      end else begin
        exp_r = pending_draws.pop_front();
        if (m_tdata[7:0] !== exp_r.slot) begin
          $error("slot_index: expected %0d, got %0d", exp_r.slot, m_tdata[7:0]);
          n_errors++;
        end
        if (m_tdata[15:8] !== exp_r.source) begin
          $error("source_index: expected %0d, got %0d", exp_r.source, m_tdata[15:8]);
          n_errors++;
        end
        if (m_tuser !== exp_r.best) begin
          $error("is_best: expected %0b, got %0b", exp_r.best, m_tuser);
          n_errors++;
        end
        if (m_tlast !== exp_r.last) begin
          $error("last: expected %0b, got %0b", exp_r.last, m_tlast);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: the slowest legal run is well under this.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** particle_resampling_engine: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Register access
  // ---------------------------------------------------------------------------
  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_MODE) mode_reg = data[1:0];
    else count_reg = data[8:0];
  endtask

  task automatic reg_check(logic [2:0] addr, logic [31:0] want);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $error("prdata @%0d: expected %0h, got %0h", addr, want, prdata);
      n_errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(logic [1:0] mode, logic [8:0] count);
    reg_write(ADDR_MODE, 32'(mode));
    reg_write(ADDR_COUNT, 32'(count));
  endtask

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(15);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_uniform();
    case ($urandom_range(19))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_registers();
    reg_check(ADDR_MODE, 32'(MODE_RESET));
    reg_check(ADDR_COUNT, 32'(COUNT_RESET));
    foreach (draws_by_mode[m]) begin
      reg_write(ADDR_MODE, m);
      reg_check(ADDR_MODE, m);
    end
    reg_write(ADDR_COUNT, 32'd511);
    reg_check(ADDR_COUNT, 32'd511);
    reg_write(ADDR_COUNT, 32'd1);
    reg_check(ADDR_COUNT, 32'd1);
  endtask

  // Weight extremes, tied maxima, every mode including the unused one,
  // search edges, zero total and a saturated copy count.
  task automatic test_modes();
    configure(MODE_NONE, 9'd4);
    load(32'd0);
    load(32'hFFFF_FFFF);
    load(32'd5);
    load(32'hFFFF_FFFF);
    repeat (4) draw($urandom());
    reg_write(ADDR_MODE, 32'(MODE_UNUSED));
    repeat (2) draw($urandom());
    reg_write(ADDR_MODE, 32'(MODE_MULTINOMIAL));
    draw(32'd0);
    draw(32'hFFFF_FFFF);
    draw(32'h8000_0000);
    reg_write(ADDR_MODE, 32'(MODE_RESIDUAL));
    repeat (4) draw($urandom());
    // zero total
    configure(MODE_MULTINOMIAL, 9'd2);
    load(32'd0);
    load(32'd0);
    draw(32'h4000_0000);
    reg_write(ADDR_MODE, 32'(MODE_RESIDUAL));
    repeat (2) draw($urandom());
    // slot 0 reloaded above the stale total: copy count saturates
    load(32'd10);
    load(32'd10);
    load(32'd1000);
    repeat (2) draw($urandom());
  endtask

  // Count of zero, a load pointer past the new count, slot counter past the
  // new count, and a mode switch in the middle of a round.
  task automatic test_count_edges();
    configure(MODE_NONE, 9'd0);
    load(32'd7);
    repeat (2) draw($urandom());
    configure(MODE_RESIDUAL, 9'd8);
    repeat (13) load(rand_weight());
    repeat (3) draw($urandom());
    reg_write(ADDR_MODE, 32'(MODE_MULTINOMIAL));
    repeat (2) draw($urandom());
    reg_write(ADDR_COUNT, 32'd3);
    draw($urandom());
    load(32'd99);
    repeat (3) draw($urandom());
  endtask

  // Full-size rounds, with a count above the maximum acting as the maximum.
  task automatic test_full_size();
    configure(MODE_MULTINOMIAL, 9'd256);
    for (int i = 0; i < NPART; i++) load(rand_weight());
    repeat (NPART) draw(rand_uniform());
    reg_write(ADDR_MODE, 32'(MODE_RESIDUAL));
    repeat (NPART) draw($urandom());
    configure(MODE_NONE, 9'd511);
    repeat (8) draw($urandom());
  endtask

  // Well-formed load/draw rounds with random sizes, plus stray loads that
  // restart a round. Residual rounds are kept small since ranking is quadratic.
  task automatic test_random(int target, int tx_pct, int rx_pct);
    logic [1:0] mode;
    int unsigned n, pick, n_draw;
    int start;
    tx_idle = tx_pct;
    rx_idle = rx_pct;
    start = n_items;
    while (n_items - start < target) begin
      mode = 2'($urandom_range(3));
      pick = $urandom_range(99);
      if (pick < 70) n = $urandom_range(1, 16);
      else if (pick < 95 || mode == MODE_RESIDUAL) n = $urandom_range(17, 32);
      else n = $urandom_range(33, NPART);
      configure(mode, n[8:0]);
      if (!all_loaded(n) || $urandom_range(1))
        repeat (n) load(rand_weight());
      n_draw = $urandom_range(1, 3 * n);
      if (n_draw > 120) n_draw = 120;
      repeat (n_draw) begin
        if ($urandom_range(99) < 6) load(rand_weight());
        draw(rand_uniform());
      end
    end
    drain();
  endtask

  initial begin
    engine_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_registers();
    test_modes();
    test_count_edges();
    test_full_size();
    test_random(300, 14, 49);
    test_random(300, 49, 14);
    test_random(300, 0, 0);
    drain();
    repeat (50) @(negedge clk);
    $display("%0d transactions sent, %0d draws predicted, %0d results checked",
             n_items, n_draws, n_results);
    $display("draws per mode: none %0d, multinomial %0d, residual %0d, unused %0d",
             draws_by_mode[0], draws_by_mode[1], draws_by_mode[2], draws_by_mode[3]);
    if (n_errors == 0 && pending_draws.size() == 0) begin
      $display("** particle_resampling_engine: PASSED **");
    end else begin
      $display("** particle_resampling_engine: FAILED **");
    end
    $finish;
  end

endmodule
